/* rtl/swsel_pkg.sv */
// ----------------------------------------------------------------------------
// swsel_pkg
// Shared types and constants for the spaced weighted selection block.
// ----------------------------------------------------------------------------
package swsel_pkg;

  // Default list capacity
  localparam int unsigned MaxItemsDef = 256;

  localparam int unsigned LocW  = 15;
  localparam int unsigned ValW  = 15;
  localparam int unsigned BestW = 23;
  localparam int unsigned StW   = 3;

  localparam logic [BestW-1:0] BestMax = {BestW{1'b1}};

  // Configuration register indexes
  localparam logic CfgRange = 1'b0;
  localparam logic CfgGap   = 1'b1;

  // Status codes
  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StRange    = 3'd1;
  localparam logic [StW-1:0] StOrder    = 3'd2;
  localparam logic [StW-1:0] StNegative = 3'd3;
  localparam logic [StW-1:0] StFull     = 3'd4;

  // Classified item passed from front to back
  typedef struct packed {
    logic [LocW-1:0] loc;
    logic [ValW-1:0] val;
    logic            range_err;
    logic            neg_err;
    logic            last;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [BestW-1:0] best;
    logic             take;
    logic [StW-1:0]   status;
    logic             last;
  } res_t;

endpackage

/* rtl/swsel_front.sv */
// ----------------------------------------------------------------------------
// swsel_front
// Accepts input beats, flags range and sign errors, and buffers them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module swsel_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [swsel_pkg::LocW-1:0]       range_limit_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [15:0]               location_i,
  input  logic signed [15:0]               item_value_i,
  input  logic                             is_last_i,
  output logic                             q_valid_o,
  output swsel_pkg::item_t                 q_item_o,
  input  logic                             q_pop_i
);

  swsel_pkg::item_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  swsel_pkg::item_t new_item;
  logic             push;

  // Classify incoming beat
  always_comb begin
    new_item.loc       = location_i[swsel_pkg::LocW-1:0];
    new_item.val       = item_value_i[swsel_pkg::ValW-1:0];
    new_item.range_err = location_i[15] ||
                         (location_i[swsel_pkg::LocW-1:0] > range_limit_i);
    new_item.neg_err   = item_value_i[15];
    new_item.last      = is_last_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

/* rtl/swsel_back.sv */
// ----------------------------------------------------------------------------
// swsel_back
// Runs the selection recurrence: order and capacity checks, back pointer
// walk over the location store, best update and the result register.
// ----------------------------------------------------------------------------
module swsel_back #(
  parameter int unsigned MaxItems = swsel_pkg::MaxItemsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [swsel_pkg::LocW-1:0]  min_gap_i,
  input  logic                        q_valid_i,
  input  swsel_pkg::item_t            q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output swsel_pkg::res_t             res_o
);

  localparam int unsigned IdxW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_BRD, S_FIN} state_e;

  state_e                      state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [CntW-1:0]             bp_q, bp_d;
  logic [swsel_pkg::StW-1:0]   sticky_q, sticky_d;
  logic [swsel_pkg::LocW-1:0]  last_loc_q, last_loc_d;
  logic [swsel_pkg::BestW-1:0] last_best_q, last_best_d;
  swsel_pkg::item_t            cur_q, cur_d;
  logic                        out_valid_q, out_valid_d;
  swsel_pkg::res_t             res_q, res_d;
  logic                        bpz_q;

  logic [swsel_pkg::LocW-1:0]  loc_mem [MaxItems];
  logic [swsel_pkg::BestW-1:0] best_mem [MaxItems];
  logic [swsel_pkg::LocW-1:0]  loc_rd_q;
  logic [swsel_pkg::BestW-1:0] best_rd_q;
  logic [CntW-1:0]             bp_m1;

  logic                        ofree;
  logic [swsel_pkg::StW-1:0]   st_new;
  logic [swsel_pkg::LocW:0]    loc_diff;
  logic [swsel_pkg::BestW-1:0] with_base;
  logic [swsel_pkg::BestW:0]   with_sum;
  logic [swsel_pkg::BestW-1:0] with_sat;
  logic [swsel_pkg::BestW-1:0] skip_val;
  logic                        take_new;
  logic                        mem_we;

  assign ofree = !out_valid_q || out_ready_i;
  assign bp_m1 = bp_q - CntW'(1);

  // Error priority for the item at the queue head
  always_comb begin
    if (sticky_q != swsel_pkg::StOk) begin
      st_new = sticky_q;
    end else if (q_item_i.range_err) begin
      st_new = swsel_pkg::StRange;
    end else if ((cnt_q != '0) && (q_item_i.loc < last_loc_q)) begin
      st_new = swsel_pkg::StOrder;
    end else if (q_item_i.neg_err) begin
      st_new = swsel_pkg::StNegative;
    end else if (cnt_q >= CntW'(MaxItems)) begin
      st_new = swsel_pkg::StFull;
    end else begin
      st_new = swsel_pkg::StOk;
    end
  end

  // Datapath for the walk and the update
  always_comb begin
    loc_diff  = {1'b0, cur_q.loc} - {1'b0, loc_rd_q};
    with_base = bpz_q ? {swsel_pkg::BestW{1'b0}} : best_rd_q;
    with_sum  = {1'b0, with_base} + (swsel_pkg::BestW + 1)'(cur_q.val);
    with_sat  = with_sum[swsel_pkg::BestW] ? swsel_pkg::BestMax
                                           : with_sum[swsel_pkg::BestW-1:0];
    skip_val  = (cnt_q == '0) ? '0 : last_best_q;
    take_new  = (with_sat > skip_val);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bp_d        = bp_q;
    sticky_d    = sticky_q;
    last_loc_d  = last_loc_q;
    last_best_d = last_best_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (st_new != swsel_pkg::StOk) begin
            if (ofree) begin
              q_pop_o     = 1'b1;
              out_valid_d = 1'b1;
              res_d       = '{best: '0, take: 1'b0, status: st_new,
                              last: q_item_i.last};
              sticky_d    = st_new;
              if (q_item_i.last) begin
                sticky_d = swsel_pkg::StOk;
                cnt_d    = '0;
                bp_d     = '0;
              end
            end
          end else begin
            q_pop_o = 1'b1;
            cur_d   = q_item_i;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = (bp_q < cnt_q) ? S_CMP : S_BRD;
      end
      S_CMP: begin
        if (loc_diff > {1'b0, min_gap_i}) begin
          bp_d    = bp_q + CntW'(1);
          state_d = S_RD;
        end else begin
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (ofree) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          res_d       = '{best: take_new ? with_sat : skip_val, take: take_new,
                          status: swsel_pkg::StOk, last: cur_q.last};
          cnt_d       = cnt_q + CntW'(1);
          last_loc_d  = cur_q.loc;
          last_best_d = take_new ? with_sat : skip_val;
          if (cur_q.last) begin
            cnt_d = '0;
            bp_d  = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      bp_q        <= '0;
      sticky_q    <= swsel_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bp_q        <= bp_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    last_loc_q  <= last_loc_d;
    last_best_q <= last_best_d;
    cur_q       <= cur_d;
    res_q       <= res_d;
  end

  // Location and best stores, registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      loc_mem[cnt_q[IdxW-1:0]]  <= cur_q.loc;
      best_mem[cnt_q[IdxW-1:0]] <= take_new ? with_sat : skip_val;
    end
    loc_rd_q  <= loc_mem[bp_q[IdxW-1:0]];
    best_rd_q <= best_mem[bp_m1[IdxW-1:0]];
    bpz_q     <= (bp_q == '0);
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/spaced_weighted_selection_dp_top.sv */
// ----------------------------------------------------------------------------
// spaced_weighted_selection_dp_top
// Flow: a queue-head item goes from S_IDLE to S_RD, through S_CMP and S_RD
//   again per back pointer step, then S_BRD and S_FIN; error items: S_IDLE.
// Throughput: one item at a time in the back end, set by the location store
//   walk; back pointer steps average at most one per item.
// Reset: asynchronous, active low; clears control, registers to 30 and 5.
// ----------------------------------------------------------------------------
module spaced_weighted_selection_dp_top #(
  parameter int unsigned MaxItems = swsel_pkg::MaxItemsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [swsel_pkg::LocW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          location_i,
  input  logic signed [15:0]          item_value_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [swsel_pkg::BestW-1:0] best_total_o,
  output logic                        take_item_o,
  output logic [swsel_pkg::StW-1:0]   status_o,
  output logic                        last_out_o
);

  logic [swsel_pkg::LocW-1:0] range_limit_q;
  logic [swsel_pkg::LocW-1:0] min_gap_q;
  logic                       q_valid;
  logic                       q_pop;
  swsel_pkg::item_t           q_item;
  swsel_pkg::res_t            res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_limit_q <= swsel_pkg::LocW'(30);
      min_gap_q     <= swsel_pkg::LocW'(5);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == swsel_pkg::CfgRange) begin
        range_limit_q <= cfg_data_i;
      end else begin
        min_gap_q <= cfg_data_i;
      end
    end
  end

  swsel_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .range_limit_i (range_limit_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .location_i    (location_i),
    .item_value_i  (item_value_i),
    .is_last_i     (is_last_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  swsel_back #(
    .MaxItems (MaxItems)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_gap_i   (min_gap_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign best_total_o = res.best;
  assign take_item_o  = res.take;
  assign status_o     = res.status;
  assign last_out_o   = res.last;

`ifndef SYNTH
  // Error results carry no total and no take flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != swsel_pkg::StOk) |-> (best_total_o == '0) && !take_item_o)
    else $error("error beat with nonzero payload");

  // A pop only happens while the queue holds a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // Status codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= swsel_pkg::StFull))
    else $error("undefined status code");
`endif

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spaced weighted selection block: random and
// directed item lists are driven over valid/ready, every result beat is
// compared with a behavioural predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

  // Expected result beat
  typedef struct {
    logic [swsel_pkg::BestW-1:0] best;
    logic                        take;
    logic [swsel_pkg::StW-1:0]   status;
    logic                        last;
  } sel_res_t;

  // Predictor plus store of pending expectations
  class sel_scoreboard;
    int unsigned               rng_lim;
    int unsigned               gap;
    int unsigned               loc_mem[swsel_pkg::MaxItemsDef];
    int unsigned               best_mem[swsel_pkg::MaxItemsDef];
    int unsigned               count;
    logic [swsel_pkg::StW-1:0] sticky;
    int unsigned               bptr;
    sel_res_t                  pending[$];
    int unsigned               mismatches;
    int unsigned               checked;

    function new();
      rng_lim = 30;
      gap = 5;
      count = 0;
      sticky = swsel_pkg::StOk;
      bptr = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic idx, int unsigned v);
      if (idx == swsel_pkg::CfgRange) rng_lim = v & 16'h7fff;
      else gap = v & 16'h7fff;
    endfunction

    // Work out the result of one accepted item
    function void note_item(logic signed [15:0] loc, logic signed [15:0] val, logic lst);
      sel_res_t    r;
      int unsigned with_v;
      int unsigned skip_v;
      int unsigned l;
      r.best = '0;
      r.take = 1'b0;
      r.last = lst;
      if (sticky == swsel_pkg::StOk) begin
        if (loc < 0 || int'(loc) > int'(rng_lim)) sticky = swsel_pkg::StRange;
        else if (count > 0 && int'(loc) < int'(loc_mem[count-1]))
          sticky = swsel_pkg::StOrder;
        else if (val < 0) sticky = swsel_pkg::StNegative;
        else if (count >= swsel_pkg::MaxItemsDef) sticky = swsel_pkg::StFull;
        else begin
          l = int'(loc);
          while (bptr < count && l - loc_mem[bptr] > gap) bptr++;
          with_v = ((bptr > 0) ? best_mem[bptr-1] : 0) + int'(val);
          if (with_v > 8388607) with_v = 8388607;
          skip_v = (count > 0) ? best_mem[count-1] : 0;
          r.take = with_v > skip_v;
          r.best = swsel_pkg::BestW'(r.take ? with_v : skip_v);
          loc_mem[count] = l;
          best_mem[count] = r.best;
          count++;
        end
      end
      r.status = sticky;
      if (sticky != swsel_pkg::StOk) begin
        r.best = '0;
        r.take = 1'b0;
      end
      pending.push_back(r);
      if (lst) begin
        count = 0;
        sticky = swsel_pkg::StOk;
        bptr = 0;
      end
    endfunction

    function void check_result(sel_res_t a);
      sel_res_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat best=%0d", a.best);
        return;
      end
      e = pending.pop_front();
      if (e.best !== a.best || e.take !== a.take || e.status !== a.status ||
          e.last !== a.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp best=%0d take=%0b st=%0d last=%0b, got %0d %0b %0d %0b",
                   e.best, e.take, e.status, e.last, a.best, a.take, a.status, a.last);
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic                            cfg_idx_i = 1'b0;
  logic [swsel_pkg::LocW-1:0]      cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic signed [15:0]              location_i = '0;
  logic signed [15:0]              item_value_i = '0;
  logic                            is_last_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [swsel_pkg::BestW-1:0]     best_total_o;
  logic                            take_item_o;
  logic [swsel_pkg::StW-1:0]       status_o;
  logic                            last_out_o;

  sel_scoreboard sb = new();
  int unsigned   lists_sent = 0;
  int unsigned   items_sent = 0;
  bit            hold_req = 1'b0;
  bit            hold_off = 1'b0;

  spaced_weighted_selection_dp_top u_top (.*);

  always #6 clk_i = ~clk_i;

  // Receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result('{best_total_o, take_item_o, status_o, last_out_o});
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) != 0) || (lists_sent % 4 == 1);
  end

  // Long hold-off, timed in cycles by the receiver side
  initial begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Drive one item beat, with an optional gap after it
  task automatic send_item(logic signed [15:0] loc, logic signed [15:0] val, logic lst);
    location_i   <= loc;
    item_value_i <= val;
    is_last_i    <= lst;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(loc, val, lst);
    items_sent++;
    if (lst) lists_sent++;
    if ($urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic idx, int unsigned v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= swsel_pkg::LocW'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random list: mostly well-formed, with sprinkled errors
  task automatic rand_list(int unsigned len, int unsigned step_max, int unsigned val_max);
    int unsigned        loc;
    logic signed [15:0] v;
    logic signed [15:0] lc;
    loc = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      loc = loc + $urandom_range(0, step_max);
      if (loc > sb.rng_lim) loc = sb.rng_lim;
      lc = 16'(loc);
      v = 16'($urandom_range(0, val_max));
      case ($urandom_range(0, 40))
        0: lc = 16'(-$urandom_range(1, 32768));
        1: lc = 16'(sb.rng_lim + $urandom_range(1, 100));
        2: lc = 16'(loc - $urandom_range(1, 3));
        3: v = 16'(-$urandom_range(1, 32768));
        default: ;
      endcase
      send_item(lc, v, i == len - 1);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, extremes, each error kind
    send_item(0, 0, 0);
    send_item(0, 16'sh7fff, 0);
    send_item(6, 100, 0);
    send_item(30, 5, 0);
    send_item(30, 50, 1);
    send_item(-1, 0, 1);
    send_item(31, 0, 1);
    send_item(10, 1, 0);
    send_item(9, 1, 0);
    send_item(12, 3, 1);
    send_item(5, -1, 0);
    send_item(16'sh8000, 16'sh8000, 1);
    send_item(40, -5, 1);
    drain();
    write_reg(swsel_pkg::CfgRange, 15'h7fff);
    write_reg(swsel_pkg::CfgGap, 0);
    send_item(16'sh7fff, 16'sh7fff, 0);
    send_item(16'sh7fff, 1, 1);
    // Too many items, then the sticky status onward
    for (int i = 0; i < swsel_pkg::MaxItemsDef + 2; i++)
      send_item(16'(i), 16'sh7fff, i == swsel_pkg::MaxItemsDef + 1);
    drain();
    write_reg(swsel_pkg::CfgGap, 15'h7fff);
    rand_list(8, 4000, 32767);
    drain();

    // Random phases across several register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(swsel_pkg::CfgRange,
                (ph == 0) ? 0 : (ph == 1) ? 15'h7fff : $urandom_range(20, 2000));
      write_reg(swsel_pkg::CfgGap,
                (ph == 2) ? 0 : (ph == 3) ? 15'h7fff : $urandom_range(0, 40));
      n = 0;
      while (n < 160) begin
        int unsigned len;
        len = $urandom_range(1, 30);
        if (ph == 4 && n == 0) hold_req = 1'b1;
        rand_list(len, $urandom_range(0, 20), (ph == 5) ? 32767 : 200);
        n += len;
      end
      drain();
    end
    $display("covered %0d items in %0d lists, %0d result beats checked",
             items_sent, lists_sent, sb.checked);
    if (sb.mismatches == 0) $display("** spaced_weighted_selection_dp_top: PASSED **");
    else $display("** spaced_weighted_selection_dp_top: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** spaced_weighted_selection_dp_top: FAILED **");
    $finish;
  end
endmodule

/* sim.f */
rtl/swsel_pkg.sv
rtl/swsel_front.sv
rtl/swsel_back.sv
rtl/spaced_weighted_selection_dp_top.sv
tb/tb_top.sv
